FILE: design/kwsc_pkg.sv
// Package for the keyword substitution cipher.
// Holds opcode and state types, letter constants and the ASCII letter decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwsc_pkg;

  localparam logic [4:0] NUM_LETTERS = 5'd26;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;

  typedef logic [4:0] letter_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_SEAL  = 2'd2,
    OP_TEXT  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SEAL = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic    hit;
    logic    lower;
    letter_t idx;
  } letter_info_t;

  // One table update: forward[pos] = letter and inverse[letter] = pos.
  typedef struct packed {
    logic    en;
    letter_t pos;
    letter_t letter;
  } table_wr_t;

  function automatic letter_info_t decode_letter(input logic [7:0] b);
    letter_info_t r;
    r = '0;
    if (b >= CHAR_UA && b <= CHAR_UZ) begin
      r.hit = 1'b1;
      r.idx = letter_t'(b - CHAR_UA);
    end else if (b >= CHAR_LA && b <= CHAR_LZ) begin
      r.hit   = 1'b1;
      r.lower = 1'b1;
      r.idx   = letter_t'(b - CHAR_LA);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/kwsc_table.sv
// 26-entry letter table: synchronous RAM, one write and one read port, registered read.
// Per-entry valid flags give the reversed alphabet for entries not written since reset.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_table
  import kwsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire letter_t wr_addr,
  input  wire letter_t wr_data,
  input  wire logic    rd_en,
  input  wire letter_t rd_addr,
  output letter_t      rd_data
);

  letter_t     mem [26];
  logic [25:0] written;
  letter_t     rd_q;
  letter_t     rd_addr_q;
  logic        rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : letter_t'(LAST_LETTER - rd_addr_q);

endmodule

`default_nettype wire

FILE: design/kwsc_ctrl.sv
// Keyword and seal sequencer: letter mask, keyword length, ready flag, Z-to-A seal walk.
// Issues table updates to both the forward and the inverse table.
// Depends on kwsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_ctrl
  import kwsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       acc,
  input  wire op_t        op,
  input  wire logic [7:0] byte_in,
  output logic            busy,
  output logic            ready,
  output table_wr_t       wr
);

  seq_state_t   state, state_next;
  logic [25:0]  mask, mask_next;
  letter_t      length, length_next;
  logic         ready_next;
  letter_t      walk, walk_next;
  letter_t      pos, pos_next;
  letter_info_t info;
  logic         key_take;
  logic         seal_take;

  assign info      = decode_letter(byte_in);
  assign key_take  = acc && op == OP_KEY && !ready && info.hit && !mask[info.idx] &&
                     length < NUM_LETTERS;
  assign seal_take = !mask[walk] && pos < NUM_LETTERS;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc && op == OP_SEAL && !ready) begin
          state_next = ST_SEAL;
        end
      end
      ST_SEAL: begin
        if (walk == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    wr   = '0;
    unique case (state)
      ST_IDLE: begin
        wr.en     = key_take;
        wr.pos    = length;
        wr.letter = info.idx;
      end
      ST_SEAL: begin
        busy      = 1'b1;
        wr.en     = seal_take;
        wr.pos    = pos;
        wr.letter = walk;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_comb begin
    mask_next   = mask;
    length_next = length;
    ready_next  = ready;
    walk_next   = walk;
    pos_next    = pos;
    if (state == ST_SEAL) begin
      if (seal_take) begin
        pos_next = pos + 5'd1;
      end
      if (walk == '0) begin
        ready_next = 1'b1;
      end else begin
        walk_next = walk - 5'd1;
      end
    end else if (acc) begin
      unique case (op)
        OP_CLEAR: begin
          mask_next   = '0;
          length_next = '0;
          ready_next  = 1'b0;
        end
        OP_KEY: begin
          if (key_take) begin
            mask_next[info.idx] = 1'b1;
            length_next         = length + 5'd1;
          end
        end
        OP_SEAL: begin
          walk_next = LAST_LETTER;
          pos_next  = length;
        end
        OP_TEXT: begin
          walk_next = walk;
        end
        default: begin
          walk_next = walk;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      mask   <= '0;
      length <= '0;
      ready  <= 1'b1;
      walk   <= '0;
      pos    <= '0;
    end else begin
      state  <= state_next;
      mask   <= mask_next;
      length <= length_next;
      ready  <= ready_next;
      walk   <= walk_next;
      pos    <= pos_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/keyword_substitution_cipher.sv
// Top level of the keyword substitution cipher: sequencer, forward and inverse tables,
// lookup stage and output register.
// Depends on kwsc_pkg, kwsc_ctrl, kwsc_table.
//
//   channel | signals                        | handshake
//   --------+--------------------------------+------------------------------
//   input   | opcode[1:0], byte_in[7:0]      | in_valid / in_stall
//   output  | byte_out[7:0]                  | out_valid / out_stall
//   config  | decrypt_mode                   | cfg_valid / cfg_ready (always 1)
//
// Text words: one per cycle while in_stall is low; result via the table read, then the
// output register. Clear and keyword words give no result.
// Seal holds in_stall while the sequencer walks Z to A through the tables.
// Reset gives the reversed alphabet in both tables, decrypt_mode 0, no result pending.
// A stalled output holds the lookup stage and then stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module keyword_substitution_cipher
  import kwsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] byte_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      byte_out,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       decrypt_mode
);

  logic         mode;
  logic         busy;
  logic         ready;
  table_wr_t    wr;
  logic         acc;
  logic         text_go;
  letter_info_t info;
  letter_t      fwd_data;
  letter_t      inv_data;
  logic         out_free;
  logic         s1_valid;
  logic         s1_map;
  logic         s1_lower;
  logic         s1_mode;
  logic [7:0]   s1_byte;
  letter_t      s1_letter;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = busy || (s1_valid && !out_free);
  assign acc       = in_valid && !in_stall;
  assign text_go   = acc && op_t'(opcode) == OP_TEXT;
  assign info      = decode_letter(byte_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= decrypt_mode;
    end
  end

  kwsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .op      (op_t'(opcode)),
    .byte_in (byte_in),
    .busy    (busy),
    .ready   (ready),
    .wr      (wr)
  );

  kwsc_table u_fwd (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr.en),
    .wr_addr (wr.pos),
    .wr_data (wr.letter),
    .rd_en   (text_go),
    .rd_addr (info.idx),
    .rd_data (fwd_data)
  );

  kwsc_table u_inv (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr.en),
    .wr_addr (wr.letter),
    .wr_data (wr.pos),
    .rd_en   (text_go),
    .rd_addr (info.idx),
    .rd_data (inv_data)
  );

  always_ff @(posedge clk) begin
    if (text_go) begin
      s1_map   <= info.hit && ready;
      s1_lower <= info.lower;
      s1_mode  <= mode;
      s1_byte  <= byte_in;
    end
    if (out_free) begin
      byte_out <= s1_map ? ((s1_lower ? CHAR_LA : CHAR_UA) + {3'b000, s1_letter}) : s1_byte;
    end
  end

  assign s1_letter = s1_mode ? inv_data : fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (text_go) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/kwsc_checker.sv
// Port-level checker for keyword_substitution_cipher, attached by bind.
// Depends on kwsc_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module kwsc_checker
  import kwsc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] opcode,
  input wire logic [7:0] byte_in,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] byte_out
);

  letter_info_t in_info;
  letter_info_t out_info;
  logic         text_acc;

  assign in_info  = decode_letter(byte_in);
  assign out_info = decode_letter(byte_out);
  assign text_acc = in_valid && !in_stall && op_t'(opcode) == OP_TEXT;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_out))
    else $error("stalled output word changed");

  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(text_acc, 2))
    else $error("output word without a text word two cycles earlier");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !$past(in_info.hit, 2) |-> byte_out == $past(byte_in, 2))
    else $error("non-letter not passed through");

  a_case_kept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && $past(in_info.hit, 2) |->
      out_info.hit && out_info.lower == $past(in_info.lower, 2))
    else $error("letter case not kept");

endmodule

bind keyword_substitution_cipher kwsc_checker u_kwsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .opcode    (opcode),
  .byte_in   (byte_in),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .byte_out  (byte_out)
);

`default_nettype wire
